// ----- rtl/core/swbd_pkg.sv -----
// Shared constants for the sliding window burst detector.
// Field widths, configuration register indexes and reset values.
// No dependencies.
package swbd_pkg;

	localparam int KEY_W     = 8;
	localparam int TIME_W    = 48;
	localparam int CNT_W     = 7;
	localparam int REP_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 48;
	// compare width for fill counts against min_repeats (fill up to 4095)
	localparam int CMP_W     = 12;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_REPEATS   = 1'b1;

	localparam logic [TIME_W-1:0] WINDOW_RST = 48'd60000;
	localparam logic [REP_W-1:0]  MIN_RST    = 6'd5;

endpackage

// ----- rtl/core/swbd_if.sv -----
// Valid/ready channel interfaces for event and burst transactions.
// Depends on swbd_pkg.
interface swbd_event_if;
	logic                       valid;
	logic                       ready;
	logic [swbd_pkg::KEY_W-1:0]  key_index;
	logic [swbd_pkg::TIME_W-1:0] event_time;

	modport source (output valid, key_index, event_time, input ready);
	modport sink   (input valid, key_index, event_time, output ready);
endinterface

interface swbd_burst_if;
	logic                       valid;
	logic                       ready;
	logic [swbd_pkg::KEY_W-1:0]  burst_key;
	logic [swbd_pkg::TIME_W-1:0] window_start;
	logic [swbd_pkg::TIME_W-1:0] window_end;
	logic [swbd_pkg::CNT_W-1:0]  repeat_count;

	modport source (output valid, burst_key, window_start, window_end, repeat_count,
		input ready);
	modport sink   (input valid, burst_key, window_start, window_end, repeat_count,
		output ready);
endinterface

// ----- rtl/core/swbd_meta_mem.sv -----
// Per-key queue head and fill memory, one write and one registered read port.
// No package dependencies.
module swbd_meta_mem #(
	parameter int KEY_SLOTS = 256,
	parameter int HEAD_W    = 6,
	parameter int FILL_W    = 7
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(KEY_SLOTS)-1:0] rd_addr,
	output logic [HEAD_W-1:0]            rd_head,
	output logic [FILL_W-1:0]            rd_fill,
	input  logic                         wr_en,
	input  logic [$clog2(KEY_SLOTS)-1:0] wr_addr,
	input  logic [HEAD_W-1:0]            wr_head,
	input  logic [FILL_W-1:0]            wr_fill
);

	logic [HEAD_W+FILL_W-1:0] mem [KEY_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_head, wr_fill};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			{rd_head, rd_fill} <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/swbd_time_mem.sv -----
// Stored event times, one ring of QUEUE_DEPTH entries per key.
// One write and one registered read port; no package dependencies.
module swbd_time_mem #(
	parameter int DEPTH  = 16384,
	parameter int DATA_W = 48
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/sliding_window_burst_detector_top.sv -----
// Sliding window burst detector: per-key time queues in block memory.
// Per event: head/fill lookup and append, then front checks that age out E entries
// (at most QUEUE_DEPTH-1); each front check is a time-memory read plus a compare.
// No new event is taken before the finish step ends; burst valid is registered from it.
// An earlier burst not yet taken stalls a finish step with a new burst, and so the input.
// Reset: a pass over every slot clears head/fill memory, no event taken; registers 60000 and 5.
module sliding_window_burst_detector_top #(
	parameter int KEY_SLOTS   = 256,
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swbd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [swbd_pkg::CFG_W-1:0]        cfg_data,
	swbd_event_if.sink                        evt,
	swbd_burst_if.source                      burst
);

	localparam int SLOT_W = $clog2(KEY_SLOTS);
	localparam int HEAD_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(KEY_SLOTS * QUEUE_DEPTH);
	localparam int TIME_W = swbd_pkg::TIME_W;
	localparam int KEY_W  = swbd_pkg::KEY_W;
	localparam int CNT_W  = swbd_pkg::CNT_W;
	localparam int REP_W  = swbd_pkg::REP_W;
	localparam int CMP_W  = swbd_pkg::CMP_W;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_META = 6'b000100,
		S_RD   = 6'b001000,
		S_CHK  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	// key modulo KEY_SLOTS, restoring remainder one bit a step
	function automatic logic [SLOT_W-1:0] slot_of(input logic [KEY_W-1:0] key);
		logic [17:0] rem;
		rem = '0;
		for (int i = KEY_W - 1; i >= 0; i--) begin
			rem = {rem[16:0], key[i]};
			if (rem >= 18'(KEY_SLOTS)) begin
				rem = rem - 18'(KEY_SLOTS);
			end
		end
		return SLOT_W'(rem);
	endfunction

	function automatic logic [HEAD_W-1:0] ring_add(input logic [HEAD_W-1:0] a,
		input logic [HEAD_W:0] b);
		logic [HEAD_W:0] s;
		s = {1'b0, a} + b;
		if (s >= (HEAD_W+1)'(QUEUE_DEPTH)) begin
			s = s - (HEAD_W+1)'(QUEUE_DEPTH);
		end
		return HEAD_W'(s);
	endfunction

	state_t state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [TIME_W-1:0] window_q;
	logic [REP_W-1:0]  min_q;

	logic [SLOT_W-1:0] slot_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;
	logic [ADDR_W-1:0] base_q;
	logic [HEAD_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic [TIME_W-1:0] start_q;

	logic              out_v_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [TIME_W-1:0] out_start_q;
	logic [TIME_W-1:0] out_end_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic evt_acc;
	logic [SLOT_W-1:0] slot_in;

	logic [HEAD_W-1:0] m_rd_head;
	logic [FILL_W-1:0] m_rd_fill;
	logic              m_we;
	logic [SLOT_W-1:0] m_waddr;
	logic [HEAD_W-1:0] m_whead;
	logic [FILL_W-1:0] m_wfill;

	logic              t_re;
	logic [ADDR_W-1:0] t_raddr;
	logic [TIME_W-1:0] t_rdata;
	logic              t_we;
	logic [ADDR_W-1:0] t_waddr;

	// append step
	logic              full;
	logic [HEAD_W-1:0] app_head;
	logic [FILL_W-1:0] app_fill;
	logic [HEAD_W-1:0] app_pos;
	logic [ADDR_W-1:0] app_base;

	// front check
	logic signed [TIME_W:0] age;
	logic                   aged_out;

	// finish step
	logic [CMP_W-1:0]  fill_c;
	logic [CMP_W-1:0]  min_c;
	logic              has_res;
	logic              trim;
	logic [REP_W-1:0]  keep;
	logic [FILL_W-1:0] drop_n;
	logic [HEAD_W-1:0] fin_head;
	logic [FILL_W-1:0] fin_fill;
	logic              fin_go;

	assign evt.ready = (state_q == S_IDLE);
	assign evt_acc   = evt.valid && evt.ready;
	assign slot_in   = slot_of(evt.key_index);

	assign full     = (m_rd_fill >= FILL_W'(QUEUE_DEPTH));
	assign app_head = full ? ring_add(m_rd_head, (HEAD_W+1)'(1)) : m_rd_head;
	assign app_fill = full ? FILL_W'(QUEUE_DEPTH - 1) : m_rd_fill;
	assign app_pos  = ring_add(app_head, (HEAD_W+1)'(app_fill));
	assign app_base = ADDR_W'(slot_q * QUEUE_DEPTH);

	assign age      = $signed({1'b0, now_q}) - $signed({1'b0, t_rdata});
	assign aged_out = age > $signed({1'b0, window_q});

	assign fill_c   = CMP_W'(fill_q);
	assign min_c    = CMP_W'(min_q);
	assign has_res  = (fill_q != '0) && (fill_c >= min_c);
	assign trim     = fill_c > min_c;
	assign keep     = ((min_q >> 1) == '0) ? REP_W'(1) : (min_q >> 1);
	assign drop_n   = fill_q - FILL_W'(keep);
	assign fin_head = trim ? ring_add(head_q, (HEAD_W+1)'(drop_n)) : head_q;
	assign fin_fill = trim ? FILL_W'(keep) : fill_q;
	assign fin_go   = !has_res || !out_v_q || burst.ready;

	assign m_we    = (state_q == S_CLR) || ((state_q == S_FIN) && fin_go);
	assign m_waddr = (state_q == S_CLR) ? clr_q : slot_q;
	assign m_whead = (state_q == S_CLR) ? '0 : fin_head;
	assign m_wfill = (state_q == S_CLR) ? '0 : fin_fill;

	assign t_we    = (state_q == S_META);
	assign t_waddr = app_base + ADDR_W'(app_pos);
	assign t_re    = (state_q == S_RD);
	assign t_raddr = base_q + ADDR_W'(head_q);

	swbd_meta_mem #(
		.KEY_SLOTS (KEY_SLOTS),
		.HEAD_W    (HEAD_W),
		.FILL_W    (FILL_W)
	) u_meta (
		.clk     (clk),
		.rd_en   (evt_acc),
		.rd_addr (slot_in),
		.rd_head (m_rd_head),
		.rd_fill (m_rd_fill),
		.wr_en   (m_we),
		.wr_addr (m_waddr),
		.wr_head (m_whead),
		.wr_fill (m_wfill)
	);

	swbd_time_mem #(
		.DEPTH  (KEY_SLOTS * QUEUE_DEPTH),
		.DATA_W (TIME_W)
	) u_time (
		.clk     (clk),
		.rd_en   (t_re),
		.rd_addr (t_raddr),
		.rd_data (t_rdata),
		.wr_en   (t_we),
		.wr_addr (t_waddr),
		.wr_data (now_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= swbd_pkg::WINDOW_RST;
			min_q    <= swbd_pkg::MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				swbd_pkg::REG_WINDOW_LENGTH: window_q <= cfg_data[TIME_W-1:0];
				swbd_pkg::REG_MIN_REPEATS:   min_q    <= cfg_data[REP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(KEY_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (evt_acc) begin
						state_q <= S_META;
					end
				end
				S_META: state_q <= S_RD;
				S_RD:   state_q <= S_CHK;
				S_CHK: begin
					if (aged_out && (fill_q != FILL_W'(1))) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if ((state_q == S_FIN) && fin_go && has_res) begin
				out_v_q <= 1'b1;
			end else if (burst.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			slot_q <= slot_in;
			key_q  <= KEY_W'(slot_in);
			now_q  <= evt.event_time;
		end
		if (state_q == S_META) begin
			base_q <= app_base;
			head_q <= app_head;
			fill_q <= app_fill + FILL_W'(1);
		end
		if ((state_q == S_CHK) && aged_out) begin
			head_q <= ring_add(head_q, (HEAD_W+1)'(1));
			fill_q <= fill_q - FILL_W'(1);
		end
		if ((state_q == S_CHK) && !aged_out) begin
			start_q <= t_rdata;
		end
		if ((state_q == S_FIN) && fin_go && has_res) begin
			out_key_q   <= key_q;
			out_start_q <= start_q;
			out_end_q   <= now_q;
			out_cnt_q   <= CNT_W'(fill_q);
		end
	end

	assign burst.valid        = out_v_q;
	assign burst.burst_key    = out_key_q;
	assign burst.window_start = out_start_q;
	assign burst.window_end   = out_end_q;
	assign burst.repeat_count = out_cnt_q;

	a_accept_meta: assert property (@(posedge clk) disable iff (!arst_n)
		evt_acc |=> (state_q == S_META))
		else $error("accepted event did not move to head/fill lookup");

	a_chk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (fill_q != '0))
		else $error("front check on an empty queue");

	a_burst_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_FIN))
		else $error("burst transaction raised outside the finish step");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for sliding_window_burst_detector_top: a directed table, then
// randomized event phases under several register settings, checked against a burst predictor.
// Depends on swbd_pkg and the swbd_event_if / swbd_burst_if interfaces.
module testbench;

	localparam int KEY_W     = swbd_pkg::KEY_W;
	localparam int TIME_W    = swbd_pkg::TIME_W;
	localparam int CNT_W     = swbd_pkg::CNT_W;
	localparam int REP_W     = swbd_pkg::REP_W;
	localparam int CFG_IDX_W = swbd_pkg::CFG_IDX_W;
	localparam int CFG_W     = swbd_pkg::CFG_W;

	localparam int SLOTS           = 256;
	localparam int DEPTH           = 64;
	localparam int DRAIN_CYCLES    = 2 * DEPTH + 5 + 60;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int IDLE_PCT        = 24;
	localparam int PHASES          = 9;
	localparam int PHASE_ITEMS     = 126;
	localparam int EXP_DEPTH       = 64;
	localparam int MAX_ROWS        = 64;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] first;
		logic [TIME_W-1:0] last;
		logic [CNT_W-1:0]  count;
	} burst_rec_t;

	typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_BURST} outcome_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [KEY_W-1:0]     key;
		logic [TIME_W-1:0]    stamp;   // event time, or register value
		outcome_t             outcome;
		burst_rec_t           typed;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	swbd_event_if evt();
	swbd_burst_if burst();

	sliding_window_burst_detector_top #(
		.KEY_SLOTS(SLOTS),
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.evt(evt),
		.burst(burst)
	);

	always #5 clk = ~clk;

	// per-key ring of event times, mirrored from the block's behavior
	logic [TIME_W-1:0] stamp_ring [SLOTS][DEPTH];
	int unsigned       ring_head [SLOTS];
	int unsigned       ring_fill [SLOTS];
	logic [TIME_W-1:0] model_window;
	logic [REP_W-1:0]  model_min;

	// expected bursts in order, written at event acceptance, read at burst acceptance
	burst_rec_t  exp_fifo [EXP_DEPTH];
	int unsigned exp_wr = 0;
	int unsigned exp_rd = 0;

	stim_row_t   rows [MAX_ROWS];
	int unsigned row_count = 0;

	int          mismatches = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned idle_cycles = 0;

	function automatic void exp_store(input burst_rec_t rec);
		exp_fifo[exp_wr % EXP_DEPTH] = rec;
		exp_wr++;
	endfunction

	function automatic void add_row(input stim_row_t r);
		rows[row_count] = r;
		row_count++;
	endfunction

	function automatic void ring_drop(input int unsigned s);
		if (ring_fill[s] != 0) begin
			ring_head[s] = (ring_head[s] + 1) % DEPTH;
			ring_fill[s]--;
		end
	endfunction

	function automatic bit predict_burst(input logic [KEY_W-1:0] key,
		input logic [TIME_W-1:0] now, output burst_rec_t rec);
		int unsigned s;
		int unsigned keep;
		longint      age;
		s = key % SLOTS;
		rec = '0;
		if (ring_fill[s] >= DEPTH)
			ring_drop(s);
		stamp_ring[s][(ring_head[s] + ring_fill[s]) % DEPTH] = now;
		ring_fill[s]++;
		// age is an exact signed difference; times going backwards stay held
		while (ring_fill[s] > 0) begin
			age = longint'({16'd0, now})
				- longint'({16'd0, stamp_ring[s][ring_head[s]]});
			if (age <= longint'({16'd0, model_window}))
				break;
			ring_drop(s);
		end
		if (ring_fill[s] == 0 || ring_fill[s] < model_min)
			return 1'b0;
		rec.key   = KEY_W'(s);
		rec.first = stamp_ring[s][ring_head[s]];
		rec.last  = stamp_ring[s][(ring_head[s] + ring_fill[s] - 1) % DEPTH];
		rec.count = CNT_W'(ring_fill[s]);
		if (ring_fill[s] > model_min) begin
			keep = model_min >> 1;
			if (keep < 1)
				keep = 1;
			while (ring_fill[s] > keep)
				ring_drop(s);
		end
		return 1'b1;
	endfunction

	function automatic logic [TIME_W-1:0] rand_upto(input logic [TIME_W-1:0] lim);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return TIME_W'(r % ({16'd0, lim} + 64'd1));
	endfunction

	function automatic void check_burst(input burst_rec_t got);
		burst_rec_t want;
		if (exp_wr == exp_rd) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected burst: key %0d start %0d end %0d count %0d",
					got.key, got.first, got.last, got.count);
			return;
		end
		want = exp_fifo[exp_rd % EXP_DEPTH];
		exp_rd++;
		if (got.key !== want.key || got.first !== want.first || got.last !== want.last
			|| got.count !== want.count) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("burst mismatch: expected key %0d start %0d end %0d count %0d,",
					want.key, want.first, want.last, want.count);
				$display("  got key %0d start %0d end %0d count %0d",
					got.key, got.first, got.last, got.count);
			end
		end
	endfunction

	function automatic stim_row_t ev_row(input logic [KEY_W-1:0] key,
		input logic [TIME_W-1:0] stamp, input outcome_t outcome, input burst_rec_t typed);
		stim_row_t r;
		r.kind    = ROW_EVENT;
		r.reg_idx = swbd_pkg::REG_WINDOW_LENGTH;
		r.key     = key;
		r.stamp   = stamp;
		r.outcome = outcome;
		r.typed   = typed;
		return r;
	endfunction

	function automatic stim_row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] value);
		stim_row_t r;
		r.kind    = ROW_WRITE;
		r.reg_idx = idx;
		r.key     = '0;
		r.stamp   = value;
		r.outcome = OUT_NONE;
		r.typed   = '0;
		return r;
	endfunction

	task automatic send_event(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp,
		input outcome_t outcome, input burst_rec_t typed);
		burst_rec_t rec;
		bit         fires;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid      <= 1'b1;
		evt.key_index  <= key;
		evt.event_time <= stamp;
		do
			@(posedge clk);
		while (evt.ready !== 1'b1);
		fires = predict_burst(key, stamp, rec);
		if (outcome == OUT_BURST)
			exp_store(typed);
		else if (outcome == OUT_MODEL && fires)
			exp_store(rec);
	endtask

	// events may leave no burst, so give the block its worst-case latency as well
	task automatic settle();
		evt.valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == swbd_pkg::REG_WINDOW_LENGTH)
			model_window = value[TIME_W-1:0];
		else
			model_min = value[REP_W-1:0];
	endtask

	initial begin
		burst_rec_t        got;
		int unsigned       hold_left;
		hold_left = 0;
		burst.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (burst.valid === 1'b1 && burst.ready === 1'b1) begin
				got.key   = burst.burst_key;
				got.first = burst.window_start;
				got.last  = burst.window_end;
				got.count = burst.repeat_count;
				check_burst(got);
			end
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				burst.ready <= 1'b0;
			end else begin
				burst.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((evt.valid === 1'b1 && evt.ready === 1'b1)
			|| (burst.valid === 1'b1 && burst.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [KEY_W-1:0]  hot_key [4];
		logic [TIME_W-1:0] hot_time [4];
		logic [TIME_W-1:0] win;
		logic [TIME_W-1:0] step;
		logic [TIME_W-1:0] stamp;
		logic [KEY_W-1:0]  key;
		logic [REP_W-1:0]  minr;
		int                ph;
		int                n;
		int                h;
		int                nhot;
		int                pick;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_idx        <= '0;
		cfg_data       <= '0;
		evt.valid      <= 1'b0;
		evt.key_index  <= '0;
		evt.event_time <= '0;
		for (int s = 0; s < SLOTS; s++) begin
			ring_head[s] = 0;
			ring_fill[s] = 0;
		end
		model_window = swbd_pkg::WINDOW_RST;
		model_min    = swbd_pkg::MIN_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window 60000, five repeats
		add_row(ev_row(8'd0, 48'd0, OUT_NONE, '0));
		add_row(ev_row(8'd0, 48'd100, OUT_NONE, '0));
		add_row(ev_row(8'd0, 48'd200, OUT_NONE, '0));
		add_row(ev_row(8'd0, 48'd300, OUT_NONE, '0));
		add_row(ev_row(8'd0, 48'd400, OUT_BURST, {8'd0, 48'd0, 48'd400, 7'd5}));
		add_row(ev_row(8'd0, 48'd500, OUT_MODEL, '0));
		add_row(ev_row(8'd255, TIME_MAX, OUT_NONE, '0));
		add_row(ev_row(8'd255, 48'd0, OUT_NONE, '0));
		// zero window, single repeat
		add_row(wr_row(swbd_pkg::REG_WINDOW_LENGTH, 48'd0));
		add_row(wr_row(swbd_pkg::REG_MIN_REPEATS, 48'd1));
		add_row(ev_row(8'd1, 48'd1000, OUT_BURST, {8'd1, 48'd1000, 48'd1000, 7'd1}));
		add_row(ev_row(8'd1, 48'd1000, OUT_MODEL, '0));
		add_row(ev_row(8'd1, 48'd1001, OUT_MODEL, '0));
		add_row(ev_row(8'd255, 48'd5, OUT_MODEL, '0));
		// widest window, zero repeats: every event reports
		add_row(wr_row(swbd_pkg::REG_WINDOW_LENGTH, TIME_MAX));
		add_row(wr_row(swbd_pkg::REG_MIN_REPEATS, 48'd0));
		add_row(ev_row(8'd2, 48'd0, OUT_MODEL, '0));
		add_row(ev_row(8'd2, TIME_MAX, OUT_MODEL, '0));
		add_row(ev_row(8'hAA, 48'hAAAA_AAAA_AAAA, OUT_MODEL, '0));
		add_row(ev_row(8'h55, 48'h5555_5555_5555, OUT_MODEL, '0));
		// short window, several entries aged out by one event
		add_row(wr_row(swbd_pkg::REG_WINDOW_LENGTH, 48'd10));
		add_row(wr_row(swbd_pkg::REG_MIN_REPEATS, 48'd2));
		add_row(ev_row(8'd7, 48'd100, OUT_NONE, '0));
		add_row(ev_row(8'd7, 48'd110, OUT_BURST, {8'd7, 48'd100, 48'd110, 7'd2}));
		add_row(ev_row(8'd7, 48'd121, OUT_NONE, '0));
		add_row(ev_row(8'd7, 48'd125, OUT_MODEL, '0));

		for (int i = 0; i < int'(row_count); i++) begin
			if (rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(rows[i].reg_idx, rows[i].stamp);
			end else begin
				send_event(rows[i].key, rows[i].stamp, rows[i].outcome, rows[i].typed);
			end
		end
		settle();

		for (ph = 0; ph < PHASES; ph++) begin
			unique case (ph)
				0: begin win = 48'd1000; minr = 6'd3; end
				1: begin win = 48'd0; minr = 6'd1; end
				2: begin win = TIME_MAX; minr = 6'd63; end
				3: begin win = rand_upto(TIME_MAX); minr = REP_W'($urandom_range(63, 1)); end
				4: begin win = 48'd50000; minr = 6'd0; end
				5: begin win = 48'd20; minr = 6'd4; end
				6: begin
					win  = TIME_W'($urandom_range(500, 1));
					minr = REP_W'($urandom_range(8, 1));
				end
				7: begin win = TIME_MAX; minr = 6'd1; end
				default: begin win = rand_upto(TIME_MAX); minr = 6'd2; end
			endcase
			write_reg(swbd_pkg::REG_WINDOW_LENGTH, win);
			write_reg(swbd_pkg::REG_MIN_REPEATS, {{(CFG_W-REP_W){1'b0}}, minr});
			quiet = (ph == 5 || ph == 6);
			if (ph == 1 || ph == 6)
				hold_req = 1'b1;
			nhot = (minr > 16) ? 1 : 1 + int'($urandom_range(3));
			for (h = 0; h < 4; h++) begin
				hot_key[h]  = KEY_W'($urandom);
				hot_time[h] = rand_upto(TIME_MAX);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				step = win / (minr + 1 + $urandom_range(minr));
				pick = int'($urandom_range(99));
				h    = int'($urandom_range(nhot - 1));
				if (pick < 10) begin
					key   = KEY_W'($urandom);
					stamp = rand_upto(TIME_MAX);
				end else begin
					key = hot_key[h];
					if (pick < 15) begin
						stamp = hot_time[h] - rand_upto(step + 3);
					end else if (pick < 19) begin
						stamp       = hot_time[h] + win + 1 + rand_upto(48'd16);
						hot_time[h] = stamp;
					end else begin
						stamp       = hot_time[h] + rand_upto(step);
						hot_time[h] = stamp;
					end
				end
				send_event(key, stamp, OUT_MODEL, '0);
			end
			settle();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/swbd_pkg.sv
rtl/core/swbd_if.sv
rtl/core/swbd_meta_mem.sv
rtl/core/swbd_time_mem.sv
rtl/core/sliding_window_burst_detector_top.sv
tb/testbench.sv
